// ----- sv/tsc_pkg.sv -----
package tsc_pkg;

   localparam int MAX_PLANES = 2;
   localparam int FRAC_BITS  = 16;

   // point and register widths
   localparam int PT_W      = 32;
   localparam int NORM_W    = 16;
   localparam int NORM_FRAC = 14;
   localparam int WIN_W     = 64;
   localparam int NVEC_W    = 3 * NORM_W;
   localparam int PCNT_W    = 2;
   localparam int CSR_IDX_W = 3;
   localparam int PIDX_W    = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;

   // constraint values (plane values in Q.30 need about 51 bits)
   localparam int G_W = 52;

   // cut parameter: -1 .. ONE+1
   localparam int T_W = FRAC_BITS + 2;
   localparam logic signed [T_W-1:0] T_ONE   = T_W'(64'd1 << FRAC_BITS);
   localparam logic signed [T_W-1:0] T_NEG1  = T_W'(-1);
   localparam logic signed [T_W-1:0] T_ABOVE = T_ONE + T_W'(1);

   // shared multiplier operands
   localparam int MA_W = PT_W + 1;
   localparam int MB_W = (T_W > NORM_W) ? T_W : NORM_W;
   localparam int MP_W = MA_W + MB_W;
   localparam logic signed [MP_W:0] MIX_HALF = (MP_W+1)'(64'd1 << (FRAC_BITS - 1));

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_TIME_WINDOW   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ENERGY_WINDOW = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PLANE_COUNT   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PLANE0_NORMAL = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_PLANE0_OFFSET = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_PLANE1_NORMAL = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_PLANE1_OFFSET = 3'd6;

   localparam logic [WIN_W-1:0] WIN_RESET = 64'h7FFF_FFFF_8000_0000;

   typedef struct packed {
      logic                  done;
      logic signed [T_W-1:0] quo;
   } div_rsp_type;

endpackage

// ----- sv/track_segment_clipper.sv -----
// A first point is only stored as the previous point. A segment runs each plane (dot
// products on the shared multiplier) and each window bound through the single shared
// divider unless parallel, then a decision, then its end point and interpolated results.
// One item at a time: no new point is taken until the segment is done and its results
// are transferred. Each result waits in the output register until transferred.
// Reset (synchronous, active high): windows open fully, planes cleared, no previous
// point, no output track open.
module track_segment_clipper (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [31:0]                req_pos_x,
   input  logic signed [31:0]                req_pos_y,
   input  logic signed [31:0]                req_pos_z,
   input  logic signed [31:0]                req_pt_time,
   input  logic signed [31:0]                req_pt_energy,
   input  logic                              req_track_first,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [31:0]                rsp_out_x,
   output logic signed [31:0]                rsp_out_y,
   output logic signed [31:0]                rsp_out_z,
   output logic signed [31:0]                rsp_out_time,
   output logic signed [31:0]                rsp_out_energy,
   output logic                              rsp_starts_track,
   output logic                              rsp_last_of_run,
   input  logic                              csr_write_en,
   input  logic [tsc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tsc_pkg::WIN_W-1:0]         csr_wdata
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_CON  = 4'd1;
   localparam logic [3:0] S_DOT  = 4'd2;
   localparam logic [3:0] S_HS   = 4'd3;
   localparam logic [3:0] S_DIV  = 4'd4;
   localparam logic [3:0] S_DEC  = 4'd5;
   localparam logic [3:0] S_SEL  = 4'd6;
   localparam logic [3:0] S_MIX  = 4'd7;
   localparam logic [3:0] S_OUT  = 4'd8;

   localparam logic [1:0] K_A    = 2'd0;
   localparam logic [1:0] K_B    = 2'd1;
   localparam logic [1:0] K_MIXL = 2'd2;
   localparam logic [1:0] K_MIXH = 2'd3;

   localparam int GW = tsc_pkg::G_W;
   localparam int TW = tsc_pkg::T_W;

   // configuration
   logic [tsc_pkg::WIN_W-1:0]  time_win_ff, time_win_in;
   logic [tsc_pkg::WIN_W-1:0]  energy_win_ff, energy_win_in;
   logic [tsc_pkg::PCNT_W-1:0] plane_cnt_ff, plane_cnt_in;
   logic [tsc_pkg::NVEC_W-1:0] normal_ff [tsc_pkg::MAX_PLANES];
   logic [tsc_pkg::NVEC_W-1:0] normal_in [tsc_pkg::MAX_PLANES];
   logic signed [31:0]         offset_ff [tsc_pkg::MAX_PLANES];
   logic signed [31:0]         offset_in [tsc_pkg::MAX_PLANES];

   // sequencer state
   logic [3:0]          state_ff, state_in;
   logic signed [31:0]  cur_ff [5];
   logic signed [31:0]  cur_in [5];
   logic signed [31:0]  prev_ff [5];
   logic signed [31:0]  prev_in [5];
   logic                have_prev_ff, have_prev_in;
   logic                run_open_ff, run_open_in;
   logic signed [TW-1:0] low_ff, low_in;
   logic signed [TW-1:0] high_ff, high_in;
   logic signed [GW-1:0] g0_ff, g0_in;
   logic signed [GW-1:0] g1_ff, g1_in;
   logic [tsc_pkg::PCNT_W-1:0] pk_ff, pk_in;
   logic [2:0]          wk_ff, wk_in;
   logic [2:0]          mcnt_ff, mcnt_in;
   logic                dir_ff, dir_in;
   logic [1:0]          kind0_ff, kind0_in;
   logic [1:0]          kind1_ff, kind1_in;
   logic                slot_ff, slot_in;
   logic signed [TW-1:0] t_ff, t_in;
   logic signed [31:0]  ad_ff, ad_in;
   logic signed [31:0]  out_ff [5];
   logic signed [31:0]  out_in [5];
   logic                start_ff, start_in;
   logic                last_ff, last_in;

   // shared units
   logic signed [tsc_pkg::MA_W-1:0] mul_a;
   logic signed [tsc_pkg::MB_W-1:0] mul_b;
   logic signed [tsc_pkg::MP_W-1:0] mul_prod;
   logic                            div_start;
   logic signed [GW-1:0]            div_num;
   logic signed [GW-1:0]            div_den;
   tsc_pkg::div_rsp_type            div_rsp;

   logic [tsc_pkg::PCNT_W-1:0] np;
   logic [2:0]                 jsel;
   logic signed [31:0]         pt_a;
   logic signed [31:0]         pt_b;
   logic [tsc_pkg::NVEC_W-1:0] nvec;
   logic signed [15:0]         ncomp;
   logic signed [GW-1:0]       prod_g;
   logic signed [GW-1:0]       off_g;
   logic signed [GW-1:0]       dg;
   logic signed [tsc_pkg::MP_W:0] rnd_sum;
   logic signed [tsc_pkg::MP_W:0] rnd_q;
   logic [tsc_pkg::WIN_W-1:0]  win;
   logic signed [31:0]         win_lo;
   logic signed [31:0]         win_hi;
   logic signed [31:0]         wa;
   logic signed [31:0]         wb;
   logic                       emit_any;
   logic                       emit_first;
   logic [1:0]                 kind;

   tsc_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (mul_prod)
   );

   tsc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .rsp   (div_rsp)
   );

   assign np = (plane_cnt_ff > tsc_pkg::PCNT_W'(tsc_pkg::MAX_PLANES)) ?
               tsc_pkg::PCNT_W'(tsc_pkg::MAX_PLANES) : plane_cnt_ff;

   // operand selection shared by dot products and interpolation
   always_comb begin
      jsel = ((state_ff == S_DOT) && (mcnt_ff >= 3'd3)) ? mcnt_ff - 3'd3 : mcnt_ff;
      pt_a = prev_ff[jsel];
      pt_b = cur_ff[jsel];
      nvec = normal_ff[pk_ff[tsc_pkg::PIDX_W-1:0]];
      unique case (jsel)
         3'd0:    ncomp = nvec[15:0];
         3'd1:    ncomp = nvec[31:16];
         default: ncomp = nvec[47:32];
      endcase
      if (state_ff == S_MIX) begin
         mul_a = tsc_pkg::MA_W'(pt_b) - tsc_pkg::MA_W'(pt_a);
         mul_b = tsc_pkg::MB_W'(t_ff);
      end else begin
         mul_a = (mcnt_ff < 3'd3) ? tsc_pkg::MA_W'(pt_a) : tsc_pkg::MA_W'(pt_b);
         mul_b = tsc_pkg::MB_W'(ncomp);
      end
      prod_g  = GW'(mul_prod);
      rnd_sum = (tsc_pkg::MP_W+1)'(mul_prod) + tsc_pkg::MIX_HALF;
      rnd_q   = rnd_sum >>> tsc_pkg::FRAC_BITS;
      off_g   = GW'(offset_ff[pk_ff[tsc_pkg::PIDX_W-1:0]]);
      dg      = g1_ff - g0_ff;
      win     = wk_ff[1] ? energy_win_ff : time_win_ff;
      win_lo  = win[31:0];
      win_hi  = win[63:32];
      wa      = wk_ff[1] ? prev_ff[4] : prev_ff[3];
      wb      = wk_ff[1] ? cur_ff[4] : cur_ff[3];
      kind    = slot_ff ? kind1_ff : kind0_ff;
   end

   always_comb begin
      time_win_in   = time_win_ff;
      energy_win_in = energy_win_ff;
      plane_cnt_in  = plane_cnt_ff;
      normal_in     = normal_ff;
      offset_in     = offset_ff;
      if (csr_write_en) begin
         if (csr_index == tsc_pkg::REG_TIME_WINDOW) time_win_in = csr_wdata;
         if (csr_index == tsc_pkg::REG_ENERGY_WINDOW) energy_win_in = csr_wdata;
         if (csr_index == tsc_pkg::REG_PLANE_COUNT) begin
            plane_cnt_in = csr_wdata[tsc_pkg::PCNT_W-1:0];
         end
         for (int k = 0; k < tsc_pkg::MAX_PLANES; k++) begin
            if (csr_index == tsc_pkg::REG_PLANE0_NORMAL + tsc_pkg::CSR_IDX_W'(2 * k)) begin
               normal_in[k] = csr_wdata[tsc_pkg::NVEC_W-1:0];
            end
            if (csr_index == tsc_pkg::REG_PLANE0_OFFSET + tsc_pkg::CSR_IDX_W'(2 * k)) begin
               offset_in[k] = csr_wdata[31:0];
            end
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      have_prev_in = have_prev_ff;
      run_open_in  = run_open_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      g0_in        = g0_ff;
      g1_in        = g1_ff;
      pk_in        = pk_ff;
      wk_in        = wk_ff;
      mcnt_in      = mcnt_ff;
      dir_in       = dir_ff;
      kind0_in     = kind0_ff;
      kind1_in     = kind1_ff;
      slot_in      = slot_ff;
      t_in         = t_ff;
      ad_in        = ad_ff;
      out_in       = out_ff;
      start_in     = start_ff;
      last_in      = last_ff;
      div_start    = 1'b0;
      div_num      = dg[GW-1] ? g0_ff : -g0_ff;
      div_den      = dg[GW-1] ? -dg : dg;
      emit_any     = 1'b0;
      emit_first   = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cur_in[0] = req_pos_x;
               cur_in[1] = req_pos_y;
               cur_in[2] = req_pos_z;
               cur_in[3] = req_pt_time;
               cur_in[4] = req_pt_energy;
               if (req_track_first || !have_prev_ff) begin
                  prev_in      = cur_in;
                  have_prev_in = 1'b1;
                  run_open_in  = 1'b0;
               end else begin
                  low_in   = tsc_pkg::T_NEG1;
                  high_in  = tsc_pkg::T_ABOVE;
                  pk_in    = '0;
                  wk_in    = '0;
                  state_in = S_CON;
               end
            end
         end
         S_CON: begin
            if (pk_ff < np) begin
               g0_in    = -(off_g <<< tsc_pkg::NORM_FRAC);
               g1_in    = -(off_g <<< tsc_pkg::NORM_FRAC);
               mcnt_in  = '0;
               state_in = S_DOT;
            end else if (wk_ff < 3'd4) begin
               if (!wk_ff[0]) begin
                  g0_in = GW'(wa) - GW'(win_lo);
                  g1_in = GW'(wb) - GW'(win_lo);
               end else begin
                  g0_in = GW'(win_hi) - GW'(wa);
                  g1_in = GW'(win_hi) - GW'(wb);
               end
               state_in = S_HS;
            end else begin
               state_in = S_DEC;
            end
         end
         S_DOT: begin
            // product of step m lands at step m+1
            if (mcnt_ff != 3'd0) begin
               if (mcnt_ff <= 3'd3) g0_in = g0_ff + prod_g;
               else                 g1_in = g1_ff + prod_g;
            end
            mcnt_in = mcnt_ff + 3'd1;
            if (mcnt_ff == 3'd6) state_in = S_HS;
         end
         S_HS: begin
            if (dg == '0) begin
               // parallel: drop all if on the cut side
               if (g0_ff[GW-1]) begin
                  low_in  = tsc_pkg::T_ABOVE;
                  high_in = tsc_pkg::T_NEG1;
               end
               if (pk_ff < np) pk_in = pk_ff + 1'b1;
               else            wk_in = wk_ff + 3'd1;
               state_in = S_CON;
            end else begin
               div_start = 1'b1;
               dir_in    = !dg[GW-1];
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (div_rsp.done) begin
               if (dir_ff) begin
                  if (div_rsp.quo > low_ff) low_in = div_rsp.quo;
               end else begin
                  if (div_rsp.quo < high_ff) high_in = div_rsp.quo;
               end
               if (pk_ff < np) pk_in = pk_ff + 1'b1;
               else            wk_in = wk_ff + 3'd1;
               state_in = S_CON;
            end
         end
         S_DEC: begin
            priority if (low_ff <= 0 && high_ff >= tsc_pkg::T_ONE) begin
               emit_any    = 1'b1;
               emit_first  = !run_open_ff;
               kind0_in    = K_A;
               kind1_in    = K_B;
               run_open_in = 1'b1;
            end else if (low_ff <= 0) begin
               run_open_in = 1'b0;
               if (high_ff > 0) begin
                  emit_any   = 1'b1;
                  emit_first = !run_open_ff;
                  kind0_in   = K_A;
                  kind1_in   = K_MIXH;
               end
            end else if (high_ff >= tsc_pkg::T_ONE) begin
               run_open_in = 1'b0;
               if (low_ff < tsc_pkg::T_ONE) begin
                  emit_any    = 1'b1;
                  emit_first  = 1'b1;
                  kind0_in    = K_MIXL;
                  kind1_in    = K_B;
                  run_open_in = 1'b1;
               end
            end else begin
               run_open_in = 1'b0;
               if (low_ff < high_ff) begin
                  emit_any   = 1'b1;
                  emit_first = 1'b1;
                  kind0_in   = K_MIXL;
                  kind1_in   = K_MIXH;
               end
            end
            if (emit_any) begin
               slot_in  = !emit_first;
               state_in = S_SEL;
            end else begin
               prev_in      = cur_ff;
               have_prev_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_SEL: begin
            start_in = !slot_ff;
            last_in  = slot_ff;
            mcnt_in  = '0;
            unique case (kind)
               K_A: begin
                  out_in   = prev_ff;
                  state_in = S_OUT;
               end
               K_B: begin
                  out_in   = cur_ff;
                  state_in = S_OUT;
               end
               K_MIXL: begin
                  t_in     = low_ff;
                  state_in = S_MIX;
               end
               default: begin
                  t_in     = high_ff;
                  state_in = S_MIX;
               end
            endcase
         end
         S_MIX: begin
            // a + round((b-a)*t / ONE), ties up
            ad_in = pt_a;
            if (mcnt_ff != 3'd0) begin
               out_in[mcnt_ff - 3'd1] = ad_ff + 32'(rnd_q);
            end
            mcnt_in = mcnt_ff + 3'd1;
            if (mcnt_ff == 3'd5) state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_ready) begin
               if (!slot_ff) begin
                  slot_in  = 1'b1;
                  state_in = S_SEL;
               end else begin
                  prev_in      = cur_ff;
                  have_prev_in = 1'b1;
                  state_in     = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_win_ff   <= tsc_pkg::WIN_RESET;
         energy_win_ff <= tsc_pkg::WIN_RESET;
         plane_cnt_ff  <= '0;
         for (int k = 0; k < tsc_pkg::MAX_PLANES; k++) begin
            normal_ff[k] <= '0;
            offset_ff[k] <= '0;
         end
         state_ff     <= S_IDLE;
         have_prev_ff <= 1'b0;
         run_open_ff  <= 1'b0;
         for (int i = 0; i < 5; i++) begin
            prev_ff[i] <= '0;
         end
      end else begin
         time_win_ff   <= time_win_in;
         energy_win_ff <= energy_win_in;
         plane_cnt_ff  <= plane_cnt_in;
         normal_ff     <= normal_in;
         offset_ff     <= offset_in;
         state_ff      <= state_in;
         have_prev_ff  <= have_prev_in;
         run_open_ff   <= run_open_in;
         prev_ff       <= prev_in;
      end
      cur_ff   <= cur_in;
      low_ff   <= low_in;
      high_ff  <= high_in;
      g0_ff    <= g0_in;
      g1_ff    <= g1_in;
      pk_ff    <= pk_in;
      wk_ff    <= wk_in;
      mcnt_ff  <= mcnt_in;
      dir_ff   <= dir_in;
      kind0_ff <= kind0_in;
      kind1_ff <= kind1_in;
      slot_ff  <= slot_in;
      t_ff     <= t_in;
      ad_ff    <= ad_in;
      out_ff   <= out_in;
      start_ff <= start_in;
      last_ff  <= last_in;
   end

   assign req_ready        = (state_ff == S_IDLE);
   assign rsp_valid        = (state_ff == S_OUT);
   assign rsp_out_x        = out_ff[0];
   assign rsp_out_y        = out_ff[1];
   assign rsp_out_z        = out_ff[2];
   assign rsp_out_time     = out_ff[3];
   assign rsp_out_energy   = out_ff[4];
   assign rsp_starts_track = start_ff;
   assign rsp_last_of_run  = last_ff;

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input and result side active together");

   a_div_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_DIV))
      else $error("divider result outside its wait state");

   a_first_point: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_track_first) |=> req_ready)
      else $error("first point of a track did not return to idle");

   a_run_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last_of_run) |=> req_ready)
      else $error("no return to idle after last result");

endmodule

// ----- sv/tsc_mul.sv -----
module tsc_mul (
   input  logic                                clock,
   input  logic signed [tsc_pkg::MA_W-1:0]     op_a,
   input  logic signed [tsc_pkg::MB_W-1:0]     op_b,
   output logic signed [tsc_pkg::MP_W-1:0]     prod
);

   logic signed [tsc_pkg::MP_W-1:0] prod_ff;
   logic signed [tsc_pkg::MP_W-1:0] prod_in;

   assign prod_in = tsc_pkg::MP_W'(op_a) * tsc_pkg::MP_W'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// ----- sv/tsc_div.sv -----
module tsc_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [tsc_pkg::G_W-1:0]    num,
   input  logic signed [tsc_pkg::G_W-1:0]    den,
   output tsc_pkg::div_rsp_type              rsp
);

   localparam int CNT_W = $clog2(tsc_pkg::FRAC_BITS + 1);
   localparam int R_W   = tsc_pkg::G_W - 1;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [R_W-1:0]        r_ff, r_in;
   logic [R_W-1:0]        d_ff, d_in;
   logic [tsc_pkg::FRAC_BITS-1:0] q_ff, q_in;
   logic signed [tsc_pkg::T_W-1:0] quo_ff, quo_in;
   logic [tsc_pkg::G_W-1:0] r_shift;
   logic [tsc_pkg::G_W-1:0] d_ext;

   // restoring division, one quotient bit per cycle; num < den on entry
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      q_in    = q_ff;
      quo_in  = quo_ff;
      r_shift = {r_ff, 1'b0};
      d_ext   = {1'b0, d_ff};
      if (start) begin
         priority if (num < 0) begin
            quo_in  = tsc_pkg::T_NEG1;
            done_in = 1'b1;
         end else if (num > den) begin
            quo_in  = tsc_pkg::T_ABOVE;
            done_in = 1'b1;
         end else if (num == den) begin
            quo_in  = tsc_pkg::T_ONE;
            done_in = 1'b1;
         end else begin
            r_in    = num[R_W-1:0];
            d_in    = den[R_W-1:0];
            q_in    = '0;
            cnt_in  = CNT_W'(tsc_pkg::FRAC_BITS);
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         if (r_shift >= d_ext) begin
            r_in = R_W'(r_shift - d_ext);
            q_in = {q_ff[tsc_pkg::FRAC_BITS-2:0], 1'b1};
         end else begin
            r_in = R_W'(r_shift);
            q_in = {q_ff[tsc_pkg::FRAC_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            quo_in  = tsc_pkg::T_W'({2'b00, q_in});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      r_ff   <= r_in;
      d_ff   <= d_in;
      q_ff   <= q_in;
      quo_ff <= quo_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quo  = quo_ff;

endmodule

// ----- test/tb_track_segment_clipper.sv -----
module tb_track_segment_clipper;

   localparam logic [tsc_pkg::CSR_IDX_W-1:0] REG_UNUSED = 3'd7;
   localparam longint ONE_T     = longint'(1) << tsc_pkg::FRAC_BITS;
   localparam int     NUM_PHASE = 10;
   localparam int     PER_PHASE = 90;
   localparam int     SETTLE    = 300;
   localparam int     LIMIT     = 1500000;

   typedef struct {
      logic signed [31:0] x, y, z, t, e;
      logic               st, last;
   } clip_pt_type;

   typedef struct {
      logic signed [31:0] x, y, z, t, e;
      logic               first;
      int                 ntyped;   // -1: take the predictor
      clip_pt_type        r0, r1;
   } row_type;

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_ready;
   logic signed [31:0] req_pos_x = 0, req_pos_y = 0, req_pos_z = 0;
   logic signed [31:0] req_pt_time = 0, req_pt_energy = 0;
   logic req_track_first = 0;
   logic rsp_valid, rsp_ready = 0;
   logic signed [31:0] rsp_out_x, rsp_out_y, rsp_out_z, rsp_out_time, rsp_out_energy;
   logic rsp_starts_track, rsp_last_of_run;
   logic csr_write_en = 0;
   logic [tsc_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [tsc_pkg::WIN_W-1:0] csr_wdata = '0;

   track_segment_clipper dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // predictor copy of configuration and state
   logic [63:0] m_twin, m_ewin;
   logic [1:0]  m_pcnt;
   logic [47:0] m_norm [2];
   logic [31:0] m_off [2];
   longint      m_prev [5];
   bit          m_have_prev, m_run_open;
   longint      cut_lo, cut_hi;

   clip_pt_type clip_q [$];
   int  errors = 0;
   bit  calm = 0;
   int  cycles = 0;

   function automatic longint cut_ratio(longint num, longint den);
      longint r, q;
      if (num < 0) return -1;
      if (num > den) return ONE_T + 1;
      if (num == den) return ONE_T;
      r = num;
      q = 0;
      for (int i = 0; i < tsc_pkg::FRAC_BITS; i++) begin
         r = r << 1;
         q = q << 1;
         if (r >= den) begin
            r = r - den;
            q = q | 1;
         end
      end
      return q;
   endfunction

   function automatic void apply_cut(longint g0, longint g1);
      longint dg, c;
      dg = g1 - g0;
      if (dg == 0) begin
         if (g0 < 0) begin
            cut_lo = ONE_T + 1;
            cut_hi = -1;
         end
      end else if (dg > 0) begin
         c = cut_ratio(-g0, dg);
         if (c > cut_lo) cut_lo = c;
      end else begin
         c = cut_ratio(g0, -dg);
         if (c < cut_hi) cut_hi = c;
      end
   endfunction

   function automatic longint plane_val(int k, longint p [5]);
      longint s;
      s = 0;
      for (int j = 0; j < 3; j++)
         s += longint'($signed(m_norm[k][16*j +: 16])) * p[j];
      return s - longint'($signed(m_off[k])) * 16384;
   endfunction

   function automatic void apply_window(logic [63:0] w, longint a, longint b);
      longint lo, hi;
      lo = longint'($signed(w[31:0]));
      hi = longint'($signed(w[63:32]));
      apply_cut(a - lo, b - lo);
      apply_cut(hi - a, hi - b);
   endfunction

   function automatic longint lerp(longint a, longint b, longint t);
      longint p;
      p = (b - a) * t + ONE_T / 2;
      return a + ((p >= 0) ? (p >>> tsc_pkg::FRAC_BITS) :
                  -((-p + ONE_T - 1) >>> tsc_pkg::FRAC_BITS));
   endfunction

   function automatic clip_pt_type make_pt(longint p [5], logic st);
      clip_pt_type r;
      r.x = p[0][31:0]; r.y = p[1][31:0]; r.z = p[2][31:0];
      r.t = p[3][31:0]; r.e = p[4][31:0];
      r.st = st;
      r.last = 0;
      return r;
   endfunction

   function automatic clip_pt_type cut_pt(longint a [5], longint b [5], longint t, logic st);
      longint c [5];
      for (int j = 0; j < 5; j++) c[j] = lerp(a[j], b[j], t);
      return make_pt(c, st);
   endfunction

   // computes the clipped points of one segment and advances the state
   function automatic void clip_segment(row_type it, ref clip_pt_type res [$]);
      longint a [5], b [5];
      int np;
      b[0] = it.x; b[1] = it.y; b[2] = it.z; b[3] = it.t; b[4] = it.e;
      a = m_prev;
      res.delete();
      if (it.first || !m_have_prev) begin
         m_run_open = 0;
      end else begin
         cut_lo = -1;
         cut_hi = ONE_T + 1;
         np = (m_pcnt > tsc_pkg::MAX_PLANES) ? tsc_pkg::MAX_PLANES : m_pcnt;
         for (int k = 0; k < np; k++) apply_cut(plane_val(k, a), plane_val(k, b));
         apply_window(m_twin, a[3], b[3]);
         apply_window(m_ewin, a[4], b[4]);
         if (cut_lo <= 0 && cut_hi >= ONE_T) begin
            if (!m_run_open) res.insert(res.size(), make_pt(a, 1));
            res.insert(res.size(), make_pt(b, 0));
            m_run_open = 1;
         end else if (cut_lo <= 0) begin
            if (cut_hi > 0) begin
               if (!m_run_open) res.insert(res.size(), make_pt(a, 1));
               res.insert(res.size(), cut_pt(a, b, cut_hi, 0));
            end
            m_run_open = 0;
         end else if (cut_hi >= ONE_T) begin
            if (cut_lo < ONE_T) begin
               res.insert(res.size(), cut_pt(a, b, cut_lo, 1));
               res.insert(res.size(), make_pt(b, 0));
               m_run_open = 1;
            end else m_run_open = 0;
         end else begin
            if (cut_lo < cut_hi) begin
               res.insert(res.size(), cut_pt(a, b, cut_lo, 1));
               res.insert(res.size(), cut_pt(a, b, cut_hi, 0));
            end
            m_run_open = 0;
         end
         if (res.size() > 0) res[res.size()-1].last = 1;
      end
      m_prev = b;
      m_have_prev = 1;
   endfunction

   task automatic csr_write(logic [tsc_pkg::CSR_IDX_W-1:0] idx, logic [63:0] val);
      @(negedge clock);
      csr_write_en <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      unique case (idx)
         tsc_pkg::REG_TIME_WINDOW:   m_twin = val;
         tsc_pkg::REG_ENERGY_WINDOW: m_ewin = val;
         tsc_pkg::REG_PLANE_COUNT:   m_pcnt = val[1:0];
         tsc_pkg::REG_PLANE0_NORMAL: m_norm[0] = val[47:0];
         tsc_pkg::REG_PLANE0_OFFSET: m_off[0] = val[31:0];
         tsc_pkg::REG_PLANE1_NORMAL: m_norm[1] = val[47:0];
         tsc_pkg::REG_PLANE1_OFFSET: m_off[1] = val[31:0];
         default: ;
      endcase
      @(negedge clock);
      csr_write_en <= 0;
   endtask

   task automatic send_point(row_type it);
      clip_pt_type res [$];
      while (!calm && $urandom_range(99) < 36) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_pos_x <= it.x; req_pos_y <= it.y; req_pos_z <= it.z;
      req_pt_time <= it.t; req_pt_energy <= it.e;
      req_track_first <= it.first;
      do @(posedge clock); while (!req_ready);
      clip_segment(it, res);
      if (it.ntyped >= 0) begin
         if (it.ntyped > 0) clip_q.insert(clip_q.size(), it.r0);
         if (it.ntyped > 1) clip_q.insert(clip_q.size(), it.r1);
      end else begin
         foreach (res[i]) clip_q.insert(clip_q.size(), res[i]);
      end
      @(negedge clock);
   endtask

   task automatic drain;
      req_valid <= 0;
      while (clip_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic logic signed [31:0] rand_coord();
      if ($urandom_range(99) < 20) return $urandom;
      return $signed($urandom_range(0, 1 << 21)) - (1 << 20);
   endfunction

   function automatic logic [31:0] rand_bound();
      return $signed($urandom_range(0, 1 << 21)) - (1 << 20);
   endfunction

   function automatic logic [15:0] rand_comp();
      if ($urandom_range(99) < 20) return 16'($urandom);
      return 16'($signed($urandom_range(0, 16'h8000)) - 16'sh4000);
   endfunction

   function automatic logic [63:0] rand_window();
      logic [31:0] lo, hi;
      int m;
      m = $urandom_range(99);
      lo = rand_bound();
      hi = lo + $urandom_range(0, 1 << 21);
      if (m < 15) return {lo - 32'd1 - $urandom_range(0, 1 << 16), lo};  // inverted
      if (m < 30) return {$urandom, $urandom};
      return {hi, lo};
   endfunction

   task automatic configure(int ph);
      if (ph == 1) begin
         // extremes: windows wide open, normals at the limits, plane count saturating
         csr_write(tsc_pkg::REG_TIME_WINDOW, 64'h7FFF_FFFF_8000_0000);
         csr_write(tsc_pkg::REG_ENERGY_WINDOW, 64'h7FFF_FFFF_8000_0000);
         csr_write(tsc_pkg::REG_PLANE_COUNT, 64'd3);
         csr_write(tsc_pkg::REG_PLANE0_NORMAL, 64'h7FFF_7FFF_7FFF);
         csr_write(tsc_pkg::REG_PLANE0_OFFSET, 64'h8000_0000);
         csr_write(tsc_pkg::REG_PLANE1_NORMAL, 64'h8000_8000_8000);
         csr_write(tsc_pkg::REG_PLANE1_OFFSET, 64'h7FFF_FFFF);
      end else if (ph == 2) begin
         // one axis plane z >= 0, so parallel segments get tested
         csr_write(tsc_pkg::REG_PLANE_COUNT, 64'd1);
         csr_write(tsc_pkg::REG_PLANE0_NORMAL, {16'h0, 16'h4000, 16'h0, 16'h0});
         csr_write(tsc_pkg::REG_PLANE0_OFFSET, 64'd0);
         csr_write(tsc_pkg::REG_TIME_WINDOW, {32'h0001_0000, 32'hFFFF_0000});
         csr_write(tsc_pkg::REG_ENERGY_WINDOW, {32'h0000_0000, 32'h0001_0000}); // inverted
      end else begin
         csr_write(tsc_pkg::REG_TIME_WINDOW, rand_window());
         csr_write(tsc_pkg::REG_ENERGY_WINDOW, rand_window());
         csr_write(tsc_pkg::REG_PLANE_COUNT, 64'($urandom_range(0, 3)));
         csr_write(tsc_pkg::REG_PLANE0_NORMAL,
                   {16'd0, rand_comp(), rand_comp(), rand_comp()});
         csr_write(tsc_pkg::REG_PLANE0_OFFSET, {32'd0, rand_coord()});
         csr_write(tsc_pkg::REG_PLANE1_NORMAL,
                   {16'd0, rand_comp(), rand_comp(), rand_comp()});
         csr_write(tsc_pkg::REG_PLANE1_OFFSET, {32'd0, rand_coord()});
      end
      csr_write(REG_UNUSED, {$urandom, $urandom});
   endtask

   task automatic random_points(int count);
      row_type it;
      int left;
      left = 0;
      it.ntyped = -1;
      it.x = 0; it.y = 0; it.z = 0; it.t = 0; it.e = 0;
      for (int n = 0; n < count; n++) begin
         it.first = 0;
         if (left == 0) begin
            left = $urandom_range(1, 12);
            it.first = ($urandom_range(9) != 0);
         end
         left--;
         if ($urandom_range(99) < 8) begin
            // noise point, fully random
            it.x = $urandom; it.y = $urandom; it.z = $urandom;
            it.t = $urandom; it.e = $urandom;
            it.first = 1'($urandom_range(1));
         end else begin
            it.x = rand_coord();
            it.y = rand_coord();
            if ($urandom_range(99) >= 20) it.z = rand_coord();
            if ($urandom_range(99) < 15) it.t = it.t;
            else it.t = it.t + $signed($urandom_range(0, 1 << 18)) - (1 << 15);
            if ($urandom_range(99) < 15) it.e = it.e;
            else it.e = it.e - $signed($urandom_range(0, 1 << 18)) + (1 << 15);
            if ($urandom_range(99) < 10) it.t = rand_coord();
         end
         send_point(it);
      end
   endtask

   function automatic clip_pt_type typed(logic signed [31:0] v, logic st, logic last);
      clip_pt_type r;
      r.x = v; r.y = v; r.z = v; r.t = v; r.e = v;
      r.st = st;
      r.last = last;
      return r;
   endfunction

   function automatic row_type drow(logic signed [31:0] v, logic first, int nt,
                                    clip_pt_type r0, clip_pt_type r1);
      row_type r;
      r.x = v; r.y = v; r.z = v; r.t = v; r.e = v;
      r.first = first;
      r.ntyped = nt;
      r.r0 = r0;
      r.r1 = r1;
      return r;
   endfunction

   initial begin
      row_type dir [$];
      clip_pt_type nil;
      nil = typed(0, 0, 0);
      m_twin = tsc_pkg::WIN_RESET; m_ewin = tsc_pkg::WIN_RESET; m_pcnt = 0;
      m_norm[0] = 0; m_norm[1] = 0; m_off[0] = 0; m_off[1] = 0;
      foreach (m_prev[j]) m_prev[j] = 0;
      m_have_prev = 0; m_run_open = 0;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(negedge clock);

      // under reset settings nothing is clipped
      dir.insert(dir.size(), drow(0, 0, 0, nil, nil));             // first point ever
      dir.insert(dir.size(), drow(32'sh0001_0000, 0, 2, typed(0, 1, 0),
                                  typed(32'sh0001_0000, 0, 1)));
      dir.insert(dir.size(), drow(32'sh7FFF_FFFF, 0, 1,
                                  typed(32'sh7FFF_FFFF, 0, 1), nil));
      dir.insert(dir.size(), drow(32'sh8000_0000, 0, 1,
                                  typed(32'sh8000_0000, 0, 1), nil));
      dir.insert(dir.size(), drow(32'sh7FFF_FFFF, 0, 1,
                                  typed(32'sh7FFF_FFFF, 0, 1), nil));
      dir.insert(dir.size(), drow(5, 1, 0, nil, nil));             // new input track
      dir.insert(dir.size(), drow(5, 0, -1, nil, nil));            // stationary segment
      dir.insert(dir.size(), drow(-5, 0, -1, nil, nil));
      dir.insert(dir.size(), drow(-1, 1, 0, nil, nil));
      dir.insert(dir.size(), drow(32'sh0000_FFFF, 0, -1, nil, nil));
      foreach (dir[i]) send_point(dir[i]);
      drain();

      for (int ph = 1; ph <= NUM_PHASE; ph++) begin
         configure(ph);
         calm = (ph == 4);
         random_points(PER_PHASE);
         drain();
      end

      if (errors == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

   always @(negedge clock)
      rsp_ready <= calm ? 1'b1 : ($urandom_range(99) >= 36);

   always @(posedge clock) begin
      clip_pt_type w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (clip_q.size() == 0) begin
            $error("unexpected result transfer x=%h", rsp_out_x);
            errors++;
         end else begin
            w = clip_q.pop_front();
            if (rsp_out_x !== w.x) begin
               $error("out_x expected %h actual %h", w.x, rsp_out_x); errors++;
            end
            if (rsp_out_y !== w.y) begin
               $error("out_y expected %h actual %h", w.y, rsp_out_y); errors++;
            end
            if (rsp_out_z !== w.z) begin
               $error("out_z expected %h actual %h", w.z, rsp_out_z); errors++;
            end
            if (rsp_out_time !== w.t) begin
               $error("out_time expected %h actual %h", w.t, rsp_out_time); errors++;
            end
            if (rsp_out_energy !== w.e) begin
               $error("out_energy expected %h actual %h", w.e, rsp_out_energy); errors++;
            end
            if (rsp_starts_track !== w.st) begin
               $error("starts_track expected %b actual %b", w.st, rsp_starts_track);
               errors++;
            end
            if (rsp_last_of_run !== w.last) begin
               $error("last_of_run expected %b actual %b", w.last, rsp_last_of_run);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

endmodule
